// ===== sv/arc_pkg.sv =====
// Shared types, constants and weight tables of the AC-resistance autorange block.
// Depends on nothing; every other file imports it.
`default_nettype none

package arc_pkg;

   localparam int SAMPLE_COUNT = 8;
   localparam int GAIN_STEPS   = 4;
   localparam int SAMPLE_W     = 16;
   localparam int WEIGHT_W     = 16;
   localparam int PROD_W       = 32;
   localparam int SUM_W        = 34;
   localparam int GAIN_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int RES_W        = 28;
   localparam int QUARTER_W    = 31;
   localparam int RECIP_W      = 31;
   localparam int RECIP_SHIFT  = 35;
   localparam int MUL_W        = QUARTER_W + RECIP_W;

   localparam logic [GAIN_W-1:0]   GAIN_RESET = 2'd1;
   // ceil(2^35 / 25): exact quotient for dividends below 2^35 / 7
   localparam logic [RECIP_W-1:0]  RECIP_25   = 31'd1374389535;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_0;
      logic [SAMPLE_W-1:0] sample_1;
      logic [SAMPLE_W-1:0] sample_2;
      logic [SAMPLE_W-1:0] sample_3;
      logic [SAMPLE_W-1:0] sample_4;
      logic [SAMPLE_W-1:0] sample_5;
      logic [SAMPLE_W-1:0] sample_6;
      logic [SAMPLE_W-1:0] sample_7;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [RES_W-1:0] resistance_uohm;
      logic [GAIN_W-1:0]       gain_used;
   } rsp_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [GAIN_W-1:0]       gain;
      logic signed [SUM_W-1:0] sum;
   } dec_type;

   typedef struct packed {
      logic lane_en;
      logic sum_en;
      logic dec_en;
      logic dec_take;
      logic mul_en;
      logic out_en;
   } pipe_ctrl_type;

   function automatic logic signed [WEIGHT_W-1:0] weight(input logic [GAIN_W-1:0] g,
                                                        input int lane);
      logic [WEIGHT_W-1:0] mag_a;
      logic [WEIGHT_W-1:0] mag_b;
      logic [WEIGHT_W-1:0] mag;
      case (g)
         2'd0: begin
            mag_a = 16'd9194;
            mag_b = 16'd22196;
         end
         2'd1: begin
            mag_a = 16'd4597;
            mag_b = 16'd11098;
         end
         2'd2: begin
            mag_a = 16'd2298;
            mag_b = 16'd5549;
         end
         default: begin
            mag_a = 16'd1149;
            mag_b = 16'd2774;
         end
      endcase
      mag = (lane == 0 || lane == 3 || lane == 4 || lane == 7) ? mag_a : mag_b;
      weight = (lane < SAMPLE_COUNT / 2) ? -$signed(mag) : $signed(mag);
   endfunction

   // smallest sum whose whole-unit part exceeds the gain's upper range
   function automatic logic signed [SUM_W-1:0] limit_sum(input logic [GAIN_W-1:0] g);
      case (g)
         2'd0:    limit_sum = SUM_W'(20100000);
         2'd1:    limit_sum = SUM_W'(10100000);
         2'd2:    limit_sum = SUM_W'(5100000);
         default: limit_sum = SUM_W'(2600000);
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== sv/ac_resistance_autorange.sv =====
// Top level of the AC-resistance autorange block: lanes, merge, scaling, flow control.
// Depends on arc_pkg, arc_lane, arc_merge and arc_scale.
//
// Use: drive one measurement (eight raw ADC samples) on req_data with req_valid;
// the beat is taken at an edge where req_valid is high and req_stall is low.
// Every beat yields exactly one rsp_data beat (status, resistance in micro-ohms,
// gain used), taken where rsp_valid is high and rsp_stall is low.
// Pipeline: rsp_valid rises once the beat has passed the five register stages
// lane products, per-gain sums, range decision, reciprocal multiply, output.
// Throughput: one beat per cycle while rsp_stall is low. The gain index is read
// and stepped in the decision stage, so each measurement sees the gain left by
// the one before.
// Stall: each stage advances when the next one is empty or advancing; a waiting
// result holds in the output register while empty stages upstream keep filling.
// req_stall rises only once all five stages hold beats and rsp_stall is high.
// Reset: synchronous; empties the pipeline and sets the gain index to 1.
`default_nettype none

module ac_resistance_autorange (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire arc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output arc_pkg::rsp_type      rsp_data
);
   import arc_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0]                                  v_in;
   logic [STAGES-1:0]                                  v_ff;
   logic [STAGES-1:0]                                  rdy;
   pipe_ctrl_type                                      ctrl;
   logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0]              smp;
   logic [SAMPLE_COUNT-1:0][GAIN_STEPS-1:0][PROD_W-1:0] lane_prod;
   logic [SAMPLE_COUNT-1:0]                            lane_zero;
   dec_type                                            dec;

   assign smp[0] = req_data.sample_0;
   assign smp[1] = req_data.sample_1;
   assign smp[2] = req_data.sample_2;
   assign smp[3] = req_data.sample_3;
   assign smp[4] = req_data.sample_4;
   assign smp[5] = req_data.sample_5;
   assign smp[6] = req_data.sample_6;
   assign smp[7] = req_data.sample_7;

   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < STAGES; k++) begin
         if (rdy[k]) begin
            v_in[k] = (k == 0) ? req_valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
      ctrl.lane_en  = rdy[0];
      ctrl.sum_en   = rdy[1];
      ctrl.dec_en   = rdy[2];
      ctrl.dec_take = rdy[2] && v_ff[1];
      ctrl.mul_en   = rdy[3];
      ctrl.out_en   = rdy[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_lane
      logic [GAIN_STEPS-1:0][WEIGHT_W-1:0] wcol;
      for (genvar g = 0; g < GAIN_STEPS; g++) begin : g_w
         assign wcol[g] = weight(GAIN_W'(g), i);
      end
      arc_lane u_lane (
         .clock  (clock),
         .en     (ctrl.lane_en),
         .sample (smp[i]),
         .weight (wcol),
         .prod   (lane_prod[i]),
         .zero   (lane_zero[i])
      );
   end

   arc_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .prod  (lane_prod),
      .zero  (lane_zero),
      .dec   (dec)
   );

   arc_scale u_scale (
      .clock (clock),
      .ctrl  (ctrl),
      .dec   (dec),
      .rsp   (rsp_data)
   );

   assign req_stall = !rdy[0];
   assign rsp_valid = v_ff[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/arc_lane.sv =====
// One sample lane: products of a sample with its weight for every gain row.
// Depends on arc_pkg.
`default_nettype none

module arc_lane (
   input  wire logic                                                  clock,
   input  wire logic                                                  en,
   input  wire logic [arc_pkg::SAMPLE_W-1:0]                          sample,
   input  wire logic [arc_pkg::GAIN_STEPS-1:0][arc_pkg::WEIGHT_W-1:0] weight,
   output logic      [arc_pkg::GAIN_STEPS-1:0][arc_pkg::PROD_W-1:0]   prod,
   output logic                                                       zero
);
   import arc_pkg::*;

   logic [GAIN_STEPS-1:0][PROD_W-1:0] prod_in;
   logic [GAIN_STEPS-1:0][PROD_W-1:0] prod_ff;
   logic                              zero_ff;

   always_comb begin
      for (int g = 0; g < GAIN_STEPS; g++) begin
         prod_in[g] = PROD_W'($signed({1'b0, sample}) * $signed(weight[g]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         zero_ff <= (sample == '0);
      end
   end

   assign prod = prod_ff;
   assign zero = zero_ff;

endmodule

`default_nettype wire

// ===== sv/arc_merge.sv =====
// Merge stage: lane sums per gain, range decision and the stored gain index.
// Depends on arc_pkg.
`default_nettype none

module arc_merge (
   input  wire logic                                                    clock,
   input  wire logic                                                    reset,
   input  wire arc_pkg::pipe_ctrl_type                                  ctrl,
   input  wire logic [arc_pkg::SAMPLE_COUNT-1:0][arc_pkg::GAIN_STEPS-1:0]
                     [arc_pkg::PROD_W-1:0]                              prod,
   input  wire logic [arc_pkg::SAMPLE_COUNT-1:0]                        zero,
   output arc_pkg::dec_type                                             dec
);
   import arc_pkg::*;

   logic [GAIN_STEPS-1:0][SUM_W-1:0] sum_in;
   logic [GAIN_STEPS-1:0][SUM_W-1:0] sum_ff;
   logic                             zero_ff;
   logic [GAIN_W-1:0]                gain_in;
   logic [GAIN_W-1:0]                gain_ff;
   logic signed [SUM_W-1:0]          sel;
   logic                             over;
   dec_type                          dec_in;
   dec_type                          dec_ff;

   always_comb begin
      logic signed [SUM_W-1:0] acc;
      for (int g = 0; g < GAIN_STEPS; g++) begin
         acc = '0;
         for (int i = 0; i < SAMPLE_COUNT; i++) begin
            acc = acc + SUM_W'($signed(prod[i][g]));
         end
         sum_in[g] = acc;
      end
   end

   always_comb begin
      sel  = $signed(sum_ff[gain_ff]);
      over = (gain_ff != '0) && (sel >= limit_sum(gain_ff));
      dec_in.gain = gain_ff;
      dec_in.sum  = sel;
      if (zero_ff) begin
         dec_in.status = STATUS_ZERO;
      end else if (over) begin
         dec_in.status = STATUS_RANGE;
      end else begin
         dec_in.status = STATUS_OK;
      end
      gain_in = (ctrl.dec_take && !zero_ff && over) ? gain_ff - 1'b1 : gain_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sum_ff  <= sum_in;
         zero_ff <= |zero;
      end
      if (ctrl.dec_en) begin
         dec_ff <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   assign dec = dec_ff;

   a_gain_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !$stable(gain_ff) |-> $past(ctrl.dec_take && !zero_ff && over))
      else $error("gain changed without a range decision");

   a_gain_down: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> gain_ff <= $past(gain_ff))
      else $error("gain index increased");

   a_range_gain: assert property (@(posedge clock) disable iff (reset)
      ctrl.dec_take && dec_in.status == STATUS_RANGE |=> dec_ff.gain != '0)
      else $error("range status issued at widest gain");

endmodule

`default_nettype wire

// ===== sv/arc_scale.sv =====
// Scaling stages: signed sum divided by 100 to micro-ohms, result register.
// Depends on arc_pkg.
`default_nettype none

module arc_scale (
   input  wire logic                   clock,
   input  wire arc_pkg::pipe_ctrl_type ctrl,
   input  wire arc_pkg::dec_type       dec,
   output arc_pkg::rsp_type            rsp
);
   import arc_pkg::*;

   logic [SUM_W-1:0]            mag;
   logic [QUARTER_W-1:0]        quarter;
   logic [MUL_W-1:0]            mul_in;
   logic [MUL_W-1:0]            mul_ff;
   logic                        neg_ff;
   logic [STATUS_W-1:0]         status_ff;
   logic [GAIN_W-1:0]           gain_ff;
   logic [RES_W-1:0]            quot;
   logic [RES_W-1:0]            res;
   rsp_type                     rsp_in;
   rsp_type                     rsp_ff;

   always_comb begin
      mag     = dec.sum[SUM_W-1] ? SUM_W'(-dec.sum) : SUM_W'(dec.sum);
      quarter = mag[QUARTER_W+1:2];
      mul_in  = MUL_W'(quarter) * MUL_W'(RECIP_25);
   end

   always_comb begin
      quot = RES_W'(mul_ff[MUL_W-1:RECIP_SHIFT]);
      res  = neg_ff ? -quot : quot;
      rsp_in.status          = status_ff;
      rsp_in.gain_used       = gain_ff;
      rsp_in.resistance_uohm = (status_ff == STATUS_OK) ? $signed(res) : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         mul_ff    <= mul_in;
         neg_ff    <= dec.sum[SUM_W-1];
         status_ff <= dec.status;
         gain_ff   <= dec.gain;
      end
      if (ctrl.out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire
